@@ src/fts_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fts_pkg
// Shared constants and codes for the telemetry float frame sender.
// ----------------------------------------------------------------------------
package fts_pkg;

    localparam int MAX_CHANNELS = 7;
    localparam int BURST_BYTES  = 16;

    // frame tail 00 00 80 7f, sent low byte first
    localparam logic [31:0] TAIL_WORD = {8'h7F, 8'h80, 8'h00, 8'h00};

    typedef enum logic [1:0] {
        CMD_WRITE      = 2'd0,
        CMD_TICK       = 2'd1,
        CMD_FIFO_EMPTY = 2'd2,
        CMD_YIELD      = 2'd3
    } cmd_t;

    typedef enum logic [3:0] {
        STAT_NONE      = 4'd0,
        STAT_STARTED   = 4'd1,
        STAT_DROPPED   = 4'd2,
        STAT_CONTINUED = 4'd3,
        STAT_DONE      = 4'd4,
        STAT_YIELD_OK  = 4'd5,
        STAT_YIELD_BSY = 4'd6,
        STAT_WRITTEN   = 4'd7,
        STAT_PAUSED    = 4'd8
    } status_t;

    localparam logic [1:0] REG_ENABLE   = 2'd0;
    localparam logic [1:0] REG_PERIOD   = 2'd1;
    localparam logic [1:0] REG_CHANNELS = 2'd2;

    localparam logic        ENABLE_RST   = 1'b1;
    localparam logic [15:0] PERIOD_RST   = 16'd1;
    localparam logic [2:0]  CHANNELS_RST = 3'd7;

endpackage

@@ src/fts_chan_store.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fts_chan_store
// Channel word memory, one write and one registered read port; entries not
// yet written read as zero.
// ----------------------------------------------------------------------------
module fts_chan_store #(
    parameter int  MAX_CHANNELS = fts_pkg::MAX_CHANNELS,
    localparam int ADDR_W       = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [31:0]       wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [31:0]       rd_data
);

    logic [31:0]             mem_reg [MAX_CHANNELS];
    logic [MAX_CHANNELS-1:0] valid_reg;
    logic [31:0]             rd_word_reg;
    logic                    rd_valid_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_word_reg <= mem_reg[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    assign rd_data = rd_valid_reg ? rd_word_reg : 32'd0;

endmodule

@@ src/fts_frame_buf.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fts_frame_buf
// Frame snapshot memory, one channel word per entry, registered read.
// ----------------------------------------------------------------------------
module fts_frame_buf #(
    parameter int  MAX_CHANNELS = fts_pkg::MAX_CHANNELS,
    localparam int ADDR_W       = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [31:0]       wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [31:0]       rd_data
);

    logic [31:0] mem_reg [MAX_CHANNELS];
    logic [31:0] rd_word_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_word_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_word_reg;

endmodule

@@ src/float_telemetry_frame_sender.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// float_telemetry_frame_sender
// Keeps channel words, divides ticks and sends float frames in bursts.
//
//   channel  direction  beat content
//   s_axis   in         command, channel slot write
//   m_axis   out        frame byte or status, counters
//   cfg      in         enable, period_ticks, channel_count
//
// one command at a time; a single-result command is answered without leaving idle
// a frame start copies the channel words; a tail-only frame skips the copy
// bursts then leave one byte per cycle while the output is not stalled,
// bounded by the frame buffer read port
// reset clears all control state and channel words; no clearing pass
// a stalled output holds the byte and the buffer read in flight
// ----------------------------------------------------------------------------
module float_telemetry_frame_sender #(
    parameter int MAX_CHANNELS = fts_pkg::MAX_CHANNELS,
    parameter int BURST_BYTES  = fts_pkg::BURST_BYTES
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // channel_index, channel_value
    input  logic [1:0]  s_axis_tuser,   // command
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [79:0] m_axis_tdata,   // tx_byte, busy_res, sent_count, drop_count
    output logic [4:0]  m_axis_tuser,   // has_byte, status
    output logic        m_axis_tlast,
    input  logic        cfg_en,
    input  logic [1:0]  cfg_addr,
    input  logic [15:0] cfg_data
);

    localparam int CH_AW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int CNT_W = $clog2(MAX_CHANNELS + 1);
    localparam int POS_W = $clog2(4 * MAX_CHANNELS + 5);
    localparam int WI_W  = POS_W - 2;
    localparam int BN_W  = $clog2(BURST_BYTES + 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_COPY,
        ST_EMIT
    } state_t;

    state_t          state_reg, state_next;
    logic            enable_reg, enable_next;
    logic [15:0]     period_reg, period_next;
    logic [2:0]      chans_reg, chans_next;
    logic            busy_reg, busy_next;
    logic            pause_reg, pause_next;
    logic [15:0]     div_reg, div_next;
    logic [31:0]     sent_reg, sent_next;
    logic [31:0]     drop_reg, drop_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [POS_W-1:0] len_reg, len_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [BN_W-1:0] burst_reg, burst_next;
    fts_pkg::status_t emit_stat_reg, emit_stat_next;
    logic [CNT_W-1:0] copy_rd_reg, copy_rd_next;
    logic [CNT_W-1:0] copy_wr_reg, copy_wr_next;
    logic            copy_pend_reg, copy_pend_next;
    logic            rd_pend_reg, rd_pend_next;
    logic            rd_tail_reg, rd_tail_next;
    logic [1:0]      rd_lane_reg, rd_lane_next;
    logic            rd_last_reg, rd_last_next;
    logic            out_valid_reg, out_valid_next;
    logic            out_has_reg, out_has_next;
    logic [7:0]      out_byte_reg, out_byte_next;
    logic            out_last_reg, out_last_next;
    fts_pkg::status_t out_stat_reg, out_stat_next;
    logic            out_busy_reg, out_busy_next;
    logic [31:0]     out_sent_reg, out_sent_next;
    logic [31:0]     out_drop_reg, out_drop_next;

    fts_pkg::cmd_t   cmd;
    logic [2:0]      in_idx;
    logic [31:0]     in_val;
    logic            accept;
    logic            out_free;
    logic [15:0]     div_inc;
    logic [CNT_W-1:0] cnt_clamp;
    logic [WI_W-1:0] word_idx;
    logic            is_tail;
    logic            more;
    logic            issue;
    logic            load_byte;
    logic            copy_issue;
    logic [31:0]     sel_word;
    logic            load_single;
    fts_pkg::status_t single_stat;

    logic             chan_wr_en;
    logic             chan_rd_en;
    logic [CH_AW-1:0] chan_rd_addr;
    logic [31:0]      chan_rd_data;
    logic             fb_wr_en;
    logic             fb_rd_en;
    logic [31:0]      fb_rd_data;

    assign cmd    = fts_pkg::cmd_t'(s_axis_tuser);
    assign in_idx = s_axis_tdata[2:0];
    assign in_val = s_axis_tdata[34:3];

    assign out_free      = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = (state_reg == ST_IDLE) && out_free;
    assign accept        = s_axis_tvalid && s_axis_tready;

    assign div_inc   = div_reg + 16'd1;
    assign cnt_clamp = (32'(chans_reg) > MAX_CHANNELS) ? CNT_W'(MAX_CHANNELS)
                                                       : CNT_W'(chans_reg);
    assign word_idx  = pos_reg[POS_W-1:2];
    assign is_tail   = (word_idx == WI_W'(cnt_reg));
    assign more      = (pos_reg < len_reg) && (burst_reg < BN_W'(BURST_BYTES));
    assign load_byte = (state_reg == ST_EMIT) && rd_pend_reg && out_free;
    assign issue     = (state_reg == ST_EMIT) && more && (!rd_pend_reg || load_byte);
    assign copy_issue = (state_reg == ST_COPY) && (copy_rd_reg < cnt_reg);
    assign sel_word  = rd_tail_reg ? fts_pkg::TAIL_WORD : fb_rd_data;

    assign chan_wr_en   = accept && (cmd == fts_pkg::CMD_WRITE) && (32'(in_idx) < MAX_CHANNELS);
    assign chan_rd_en   = copy_issue;
    assign chan_rd_addr = CH_AW'(copy_rd_reg);
    assign fb_wr_en     = (state_reg == ST_COPY) && copy_pend_reg;
    assign fb_rd_en     = issue && !is_tail;

    fts_chan_store #(
        .MAX_CHANNELS (MAX_CHANNELS)
    ) u_chan_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (chan_wr_en),
        .wr_addr (CH_AW'(in_idx)),
        .wr_data (in_val),
        .rd_en   (chan_rd_en),
        .rd_addr (chan_rd_addr),
        .rd_data (chan_rd_data)
    );

    fts_frame_buf #(
        .MAX_CHANNELS (MAX_CHANNELS)
    ) u_frame_buf (
        .clk     (clk),
        .wr_en   (fb_wr_en),
        .wr_addr (CH_AW'(copy_wr_reg)),
        .wr_data (chan_rd_data),
        .rd_en   (fb_rd_en),
        .rd_addr (CH_AW'(word_idx)),
        .rd_data (fb_rd_data)
    );

    always_comb
    begin
        state_next     = state_reg;
        enable_next    = enable_reg;
        period_next    = period_reg;
        chans_next     = chans_reg;
        busy_next      = busy_reg;
        pause_next     = pause_reg;
        div_next       = div_reg;
        sent_next      = sent_reg;
        drop_next      = drop_reg;
        cnt_next       = cnt_reg;
        len_next       = len_reg;
        pos_next       = pos_reg;
        burst_next     = burst_reg;
        emit_stat_next = emit_stat_reg;
        copy_rd_next   = copy_rd_reg;
        copy_wr_next   = copy_wr_reg;
        copy_pend_next = 1'b0;
        rd_pend_next   = rd_pend_reg;
        rd_tail_next   = rd_tail_reg;
        rd_lane_next   = rd_lane_reg;
        rd_last_next   = rd_last_reg;
        load_single    = 1'b0;
        single_stat    = fts_pkg::STAT_NONE;

        if (cfg_en)
        begin
            case (cfg_addr)
                fts_pkg::REG_ENABLE:   enable_next = cfg_data[0];
                fts_pkg::REG_PERIOD:   period_next = cfg_data;
                fts_pkg::REG_CHANNELS: chans_next  = cfg_data[2:0];
                default: ;
            endcase
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (cmd)
                        fts_pkg::CMD_WRITE:
                        begin
                            load_single = 1'b1;
                            single_stat = chan_wr_en ? fts_pkg::STAT_WRITTEN
                                                     : fts_pkg::STAT_NONE;
                        end
                        fts_pkg::CMD_TICK:
                        begin
                            if (!enable_reg)
                            begin
                                div_next    = 16'd0;
                                load_single = 1'b1;
                            end
                            else if (pause_reg)
                            begin
                                pause_next  = 1'b0;
                                div_next    = 16'd0;
                                load_single = 1'b1;
                                single_stat = fts_pkg::STAT_PAUSED;
                            end
                            else if (div_inc < period_reg)
                            begin
                                div_next    = div_inc;
                                load_single = 1'b1;
                            end
                            else if (busy_reg)
                            begin
                                div_next    = 16'd0;
                                drop_next   = drop_reg + 32'd1;
                                load_single = 1'b1;
                                single_stat = fts_pkg::STAT_DROPPED;
                            end
                            else
                            begin
                                div_next       = 16'd0;
                                busy_next      = 1'b1;
                                cnt_next       = cnt_clamp;
                                len_next       = POS_W'({cnt_clamp, 2'b00}) + POS_W'(4);
                                pos_next       = '0;
                                burst_next     = '0;
                                copy_rd_next   = '0;
                                rd_pend_next   = 1'b0;
                                emit_stat_next = fts_pkg::STAT_STARTED;
                                state_next     = (cnt_clamp == '0) ? ST_EMIT : ST_COPY;
                            end
                        end
                        fts_pkg::CMD_FIFO_EMPTY:
                        begin
                            if (!busy_reg)
                            begin
                                load_single = 1'b1;
                            end
                            else if (pos_reg < len_reg)
                            begin
                                burst_next     = '0;
                                rd_pend_next   = 1'b0;
                                emit_stat_next = fts_pkg::STAT_CONTINUED;
                                state_next     = ST_EMIT;
                            end
                            else
                            begin
                                busy_next   = 1'b0;
                                sent_next   = sent_reg + 32'd1;
                                load_single = 1'b1;
                                single_stat = fts_pkg::STAT_DONE;
                            end
                        end
                        fts_pkg::CMD_YIELD:
                        begin
                            load_single = 1'b1;
                            if (busy_reg)
                            begin
                                single_stat = fts_pkg::STAT_YIELD_BSY;
                            end
                            else
                            begin
                                pause_next  = 1'b1;
                                single_stat = fts_pkg::STAT_YIELD_OK;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_COPY:
            begin
                // read slot k while slot k-1 lands in the frame buffer
                if (copy_issue)
                begin
                    copy_rd_next   = copy_rd_reg + CNT_W'(1);
                    copy_wr_next   = copy_rd_reg;
                    copy_pend_next = 1'b1;
                end
                else
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (issue)
                begin
                    pos_next     = pos_reg + POS_W'(1);
                    burst_next   = burst_reg + BN_W'(1);
                    rd_tail_next = is_tail;
                    rd_lane_next = pos_reg[1:0];
                    rd_last_next = (pos_reg + POS_W'(1) == len_reg)
                                || (burst_reg + BN_W'(1) == BN_W'(BURST_BYTES));
                end
                rd_pend_next = issue || (rd_pend_reg && !load_byte);
                if (load_byte && rd_last_reg)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase

        out_valid_next = out_valid_reg && !m_axis_tready;
        out_has_next   = out_has_reg;
        out_byte_next  = out_byte_reg;
        out_last_next  = out_last_reg;
        out_stat_next  = out_stat_reg;
        out_busy_next  = out_busy_reg;
        out_sent_next  = out_sent_reg;
        out_drop_next  = out_drop_reg;
        if (load_single || load_byte)
        begin
            out_valid_next = 1'b1;
            out_has_next   = load_byte;
            out_byte_next  = load_byte ? 8'(sel_word >> {rd_lane_reg, 3'b000}) : 8'd0;
            out_last_next  = load_single || rd_last_reg;
            out_stat_next  = load_byte ? emit_stat_reg : single_stat;
            out_busy_next  = busy_next;
            out_sent_next  = sent_next;
            out_drop_next  = drop_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            enable_reg    <= fts_pkg::ENABLE_RST;
            period_reg    <= fts_pkg::PERIOD_RST;
            chans_reg     <= fts_pkg::CHANNELS_RST;
            busy_reg      <= 1'b0;
            pause_reg     <= 1'b0;
            div_reg       <= '0;
            sent_reg      <= '0;
            drop_reg      <= '0;
            cnt_reg       <= '0;
            len_reg       <= '0;
            pos_reg       <= '0;
            burst_reg     <= '0;
            emit_stat_reg <= fts_pkg::STAT_NONE;
            copy_rd_reg   <= '0;
            copy_wr_reg   <= '0;
            copy_pend_reg <= 1'b0;
            rd_pend_reg   <= 1'b0;
            rd_tail_reg   <= 1'b0;
            rd_lane_reg   <= '0;
            rd_last_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            enable_reg    <= enable_next;
            period_reg    <= period_next;
            chans_reg     <= chans_next;
            busy_reg      <= busy_next;
            pause_reg     <= pause_next;
            div_reg       <= div_next;
            sent_reg      <= sent_next;
            drop_reg      <= drop_next;
            cnt_reg       <= cnt_next;
            len_reg       <= len_next;
            pos_reg       <= pos_next;
            burst_reg     <= burst_next;
            emit_stat_reg <= emit_stat_next;
            copy_rd_reg   <= copy_rd_next;
            copy_wr_reg   <= copy_wr_next;
            copy_pend_reg <= copy_pend_next;
            rd_pend_reg   <= rd_pend_next;
            rd_tail_reg   <= rd_tail_next;
            rd_lane_reg   <= rd_lane_next;
            rd_last_reg   <= rd_last_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_has_reg  <= out_has_next;
        out_byte_reg <= out_byte_next;
        out_last_reg <= out_last_next;
        out_stat_reg <= out_stat_next;
        out_busy_reg <= out_busy_next;
        out_sent_reg <= out_sent_next;
        out_drop_reg <= out_drop_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tuser  = {out_stat_reg, out_has_reg};
    assign m_axis_tdata  = {7'd0, out_drop_reg, out_sent_reg, out_busy_reg, out_byte_reg};

    a_pos_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= len_reg)
        else $error("send position beyond frame length");

    a_burst_bound: assert property (@(posedge clk) disable iff (!rst_n)
        burst_reg <= BN_W'(BURST_BYTES))
        else $error("burst longer than allowed");

    a_done_counts: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy_reg) |-> sent_reg == $past(sent_reg) + 32'd1)
        else $error("frame finished without counting it");

    a_byte_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> busy_reg)
        else $error("frame byte beat outside a frame");

endmodule

@@ tb/sv/fts_frame_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fts_frame_checker
// Watches the command, frame and register ports of the float frame sender,
// keeps its own copy of the channel words, divider and frame state, works out
// the beats each accepted command must produce and compares every output
// beat field by field against the oldest one still owed.
// ----------------------------------------------------------------------------
module fts_frame_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // channel_index, channel_value
    input  logic [1:0]  s_axis_tuser,   // command
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [79:0] m_axis_tdata,   // tx_byte, busy_res, sent_count, drop_count
    input  logic [4:0]  m_axis_tuser,   // has_byte, status
    input  logic        m_axis_tlast,
    input  logic        cfg_en,
    input  logic [1:0]  cfg_addr,
    input  logic [15:0] cfg_data,
    output int          mismatch_count,
    output int          owed_beats
);

    localparam int FRAME_BYTES = fts_pkg::MAX_CHANNELS * 4 + 4;

    typedef struct packed {
        logic             has_byte;
        logic [7:0]       tx_byte;
        logic             last;
        fts_pkg::status_t status;
        logic             busy;
        logic [31:0]      sent;
        logic [31:0]      dropped;
    } frame_beat_t;

    frame_beat_t owed_queue[$];

    logic [31:0] chan_word [0:fts_pkg::MAX_CHANNELS-1];
    logic [7:0]  frame_buf [0:FRAME_BYTES-1];
    int unsigned send_pos;
    int unsigned frame_len;
    logic        busy;
    logic        paused;
    logic [15:0] divider;
    logic [31:0] sent_frames;
    logic [31:0] dropped_frames;
    logic        enable_r;
    logic [15:0] period_r;
    logic [2:0]  chan_count_r;

    function automatic void owe_beat(logic has, logic [7:0] data, logic last,
                                     fts_pkg::status_t st);
        frame_beat_t b;
        b.has_byte = has;
        b.tx_byte  = data;
        b.last     = last;
        b.status   = st;
        b.busy     = busy;
        b.sent     = sent_frames;
        b.dropped  = dropped_frames;
        owed_queue.push_back(b);
    endfunction

    function automatic void owe_burst(fts_pkg::status_t st);
        int n;
        n = 0;
        while (send_pos < frame_len && n < fts_pkg::BURST_BYTES)
        begin
            send_pos++;
            n++;
            owe_beat(1'b1, frame_buf[send_pos-1],
                     (send_pos == frame_len) || (n == fts_pkg::BURST_BYTES), st);
        end
    endfunction

    function automatic void build_frame();
        int unsigned cnt;
        int unsigned len;
        cnt = chan_count_r;
        if (cnt > fts_pkg::MAX_CHANNELS)
            cnt = fts_pkg::MAX_CHANNELS;
        len = 0;
        for (int i = 0; i < cnt; i++)
        begin
            for (int b = 0; b < 4; b++)
            begin
                frame_buf[len] = chan_word[i][8*b +: 8];
                len++;
            end
        end
        for (int b = 0; b < 4; b++)
        begin
            frame_buf[len] = fts_pkg::TAIL_WORD[8*b +: 8];
            len++;
        end
        frame_len = len;
        send_pos  = 0;
    endfunction

    function automatic void predict_command(fts_pkg::cmd_t cmd, logic [2:0] idx,
                                            logic [31:0] val);
        case (cmd)
            fts_pkg::CMD_WRITE:
            begin
                if (idx < fts_pkg::MAX_CHANNELS)
                begin
                    chan_word[idx] = val;
                    owe_beat(1'b0, 8'd0, 1'b1, fts_pkg::STAT_WRITTEN);
                end
                else
                    owe_beat(1'b0, 8'd0, 1'b1, fts_pkg::STAT_NONE);
            end
            fts_pkg::CMD_TICK:
            begin
                if (!enable_r)
                begin
                    divider = '0;
                    owe_beat(1'b0, 8'd0, 1'b1, fts_pkg::STAT_NONE);
                end
                else if (paused)
                begin
                    paused  = 1'b0;
                    divider = '0;
                    owe_beat(1'b0, 8'd0, 1'b1, fts_pkg::STAT_PAUSED);
                end
                else
                begin
                    divider = divider + 16'd1;
                    if (divider < period_r)
                        owe_beat(1'b0, 8'd0, 1'b1, fts_pkg::STAT_NONE);
                    else
                    begin
                        divider = '0;
                        if (busy)
                        begin
                            dropped_frames = dropped_frames + 32'd1;
                            owe_beat(1'b0, 8'd0, 1'b1, fts_pkg::STAT_DROPPED);
                        end
                        else
                        begin
                            build_frame();
                            busy = 1'b1;
                            owe_burst(fts_pkg::STAT_STARTED);
                        end
                    end
                end
            end
            fts_pkg::CMD_FIFO_EMPTY:
            begin
                if (!busy)
                    owe_beat(1'b0, 8'd0, 1'b1, fts_pkg::STAT_NONE);
                else if (send_pos < frame_len)
                    owe_burst(fts_pkg::STAT_CONTINUED);
                else
                begin
                    busy        = 1'b0;
                    sent_frames = sent_frames + 32'd1;
                    owe_beat(1'b0, 8'd0, 1'b1, fts_pkg::STAT_DONE);
                end
            end
            default:
            begin
                if (busy)
                    owe_beat(1'b0, 8'd0, 1'b1, fts_pkg::STAT_YIELD_BSY);
                else
                begin
                    paused = 1'b1;
                    owe_beat(1'b0, 8'd0, 1'b1, fts_pkg::STAT_YIELD_OK);
                end
            end
        endcase
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want)
        begin
            $error("%s expected 0x%0h actual 0x%0h", name, want, got);
            mismatch_count++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            owed_queue.delete();
            for (int i = 0; i < fts_pkg::MAX_CHANNELS; i++)
                chan_word[i] = '0;
            send_pos       = 0;
            frame_len      = 0;
            busy           = 1'b0;
            paused         = 1'b0;
            divider        = '0;
            sent_frames    = '0;
            dropped_frames = '0;
            enable_r       = fts_pkg::ENABLE_RST;
            period_r       = fts_pkg::PERIOD_RST;
            chan_count_r   = fts_pkg::CHANNELS_RST;
            mismatch_count = 0;
        end
        else
        begin
            if (cfg_en)
            begin
                case (cfg_addr)
                    fts_pkg::REG_ENABLE:   enable_r     = cfg_data[0];
                    fts_pkg::REG_PERIOD:   period_r     = cfg_data;
                    fts_pkg::REG_CHANNELS: chan_count_r = cfg_data[2:0];
                    default: ;
                endcase
            end

            if (s_axis_tvalid && s_axis_tready)
                predict_command(fts_pkg::cmd_t'(s_axis_tuser), s_axis_tdata[2:0],
                                s_axis_tdata[34:3]);

            if (m_axis_tvalid && m_axis_tready)
            begin
                if (owed_queue.size() == 0)
                begin
                    $error("output beat with nothing owed: tdata 0x%0h tuser 0x%0h",
                           m_axis_tdata, m_axis_tuser);
                    mismatch_count++;
                end
                else
                begin
                    frame_beat_t want;
                    want = owed_queue.pop_front();
                    check_field("has_byte",   want.has_byte, m_axis_tuser[0]);
                    check_field("tx_byte",    want.tx_byte,  m_axis_tdata[7:0]);
                    check_field("last",       want.last,     m_axis_tlast);
                    check_field("status",     want.status,   m_axis_tuser[4:1]);
                    check_field("busy_res",   want.busy,     m_axis_tdata[8]);
                    check_field("sent_count", want.sent,     m_axis_tdata[40:9]);
                    check_field("drop_count", want.dropped,  m_axis_tdata[72:41]);
                end
            end
        end
        owed_beats = owed_queue.size();
    end

endmodule

@@ tb/sv/tb_float_telemetry_frame_sender.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_float_telemetry_frame_sender
// Drives channel writes, ticks, fifo-empty events and yield requests into the
// float frame sender through several register settings, first a directed set
// of corner cases and then random command mixes, with bursty input and a
// stalling output side; the checker module judges every output beat.
// ----------------------------------------------------------------------------
module tb_float_telemetry_frame_sender;

    localparam int IDLE_LIMIT = 2000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata = '0;     // channel_index, channel_value
    logic [1:0]  s_axis_tuser = '0;     // command
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [79:0] m_axis_tdata;          // tx_byte, busy_res, sent_count, drop_count
    logic [4:0]  m_axis_tuser;          // has_byte, status
    logic        m_axis_tlast;
    logic        cfg_en = 1'b0;
    logic [1:0]  cfg_addr = '0;
    logic [15:0] cfg_data = '0;

    int          mismatch_count;
    int          owed_beats;
    int          idle_cycles = 0;
    int unsigned burst_left = 0;
    int unsigned rdy_cycle = 0;
    int unsigned rdy_mode = 0;

    always #2 clk = ~clk;

    float_telemetry_frame_sender dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_en        (cfg_en),
        .cfg_addr      (cfg_addr),
        .cfg_data      (cfg_data)
    );

    fts_frame_checker checker_i (
        .clk            (clk),
        .rst_n          (rst_n),
        .s_axis_tvalid  (s_axis_tvalid),
        .s_axis_tready  (s_axis_tready),
        .s_axis_tdata   (s_axis_tdata),
        .s_axis_tuser   (s_axis_tuser),
        .m_axis_tvalid  (m_axis_tvalid),
        .m_axis_tready  (m_axis_tready),
        .m_axis_tdata   (m_axis_tdata),
        .m_axis_tuser   (m_axis_tuser),
        .m_axis_tlast   (m_axis_tlast),
        .cfg_en         (cfg_en),
        .cfg_addr       (cfg_addr),
        .cfg_data       (cfg_data),
        .mismatch_count (mismatch_count),
        .owed_beats     (owed_beats)
    );

    // output side stall pattern, with a randomly chosen style that switches periodically
    always @(negedge clk)
    begin
        rdy_cycle++;
        if (rdy_cycle % 97 == 0)
            rdy_mode = $urandom_range(0, 3);
        case (rdy_mode)
            0:       m_axis_tready <= 1'b1;
            1:       m_axis_tready <= ($urandom_range(0, 3) != 0);
            2:       m_axis_tready <= ((rdy_cycle % 8) < 5);
            default: m_axis_tready <= $urandom_range(0, 1);
        endcase
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_en)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("float_telemetry_frame_sender verification failed");
            $finish;
        end
    end

    task automatic drive_cmd(input fts_pkg::cmd_t cmd, input logic [2:0] idx,
                             input logic [31:0] val);
        int unsigned gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, 5);
            if (gap > 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(1, 8);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= {5'd0, val, idx};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        @(negedge clk);
        burst_left--;
    endtask

    // stop sending and let every owed beat drain before a register change
    task automatic drain_frames();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        while (owed_beats != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic load_settings(input logic en, input logic [15:0] period,
                                 input logic [2:0] channels);
        cfg_en   <= 1'b1;
        cfg_addr <= fts_pkg::REG_ENABLE;
        cfg_data <= {15'd0, en};
        @(negedge clk);
        cfg_addr <= fts_pkg::REG_PERIOD;
        cfg_data <= period;
        @(negedge clk);
        cfg_addr <= fts_pkg::REG_CHANNELS;
        cfg_data <= {13'd0, channels};
        @(negedge clk);
        cfg_en   <= 1'b0;
        @(negedge clk);
    endtask

    task automatic random_commands(input int unsigned count);
        fts_pkg::cmd_t cmd;
        logic [2:0]    idx;
        logic [31:0]   val;
        int unsigned   pick;
        repeat (count)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 30)
                cmd = fts_pkg::CMD_WRITE;
            else if (pick < 55)
                cmd = fts_pkg::CMD_TICK;
            else if (pick < 90)
                cmd = fts_pkg::CMD_FIFO_EMPTY;
            else
                cmd = fts_pkg::CMD_YIELD;
            idx = ($urandom_range(0, 9) == 0) ? 3'd7 : 3'($urandom_range(0, 6));
            val = $urandom;
            if ($urandom_range(0, 7) == 0)
                val = {32{val[0]}};
            drive_cmd(cmd, idx, val);
        end
    endtask

    initial
    begin
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset settings: enabled, period 1, all channels
        drive_cmd(fts_pkg::CMD_WRITE, 3'd0, 32'h0000_0000);
        drive_cmd(fts_pkg::CMD_WRITE, 3'd1, 32'hFFFF_FFFF);
        drive_cmd(fts_pkg::CMD_WRITE, 3'd2, 32'h8000_0000);
        drive_cmd(fts_pkg::CMD_WRITE, 3'd3, 32'h7FFF_FFFF);
        drive_cmd(fts_pkg::CMD_WRITE, 3'd4, 32'hAAAA_AAAA);
        drive_cmd(fts_pkg::CMD_WRITE, 3'd5, 32'h5555_5555);
        drive_cmd(fts_pkg::CMD_WRITE, 3'd6, 32'h1234_5678);
        drive_cmd(fts_pkg::CMD_WRITE, 3'd7, 32'hDEAD_BEEF);     // slot out of range
        drive_cmd(fts_pkg::CMD_FIFO_EMPTY, 3'd0, 32'h0);         // nothing in flight
        drive_cmd(fts_pkg::CMD_YIELD, 3'd0, 32'h0);
        drive_cmd(fts_pkg::CMD_TICK, 3'd0, 32'h0);               // skipped by the yield
        drive_cmd(fts_pkg::CMD_TICK, 3'd0, 32'h0);               // full frame starts
        drive_cmd(fts_pkg::CMD_TICK, 3'd0, 32'h0);               // dropped while busy
        drive_cmd(fts_pkg::CMD_YIELD, 3'd0, 32'h0);              // refused while busy
        drive_cmd(fts_pkg::CMD_FIFO_EMPTY, 3'd0, 32'h0);
        drive_cmd(fts_pkg::CMD_FIFO_EMPTY, 3'd0, 32'h0);
        drain_frames();

        // tail-only frame with period zero
        load_settings(1'b1, 16'd0, 3'd0);
        drive_cmd(fts_pkg::CMD_TICK, 3'd0, 32'h0);
        drive_cmd(fts_pkg::CMD_FIFO_EMPTY, 3'd0, 32'h0);
        drain_frames();

        load_settings(1'b0, 16'd1, 3'd7);
        drive_cmd(fts_pkg::CMD_TICK, 3'd0, 32'h0);
        drain_frames();

        // divider counts up to the period
        load_settings(1'b1, 16'd3, 3'd2);
        drive_cmd(fts_pkg::CMD_TICK, 3'd0, 32'h0);
        drive_cmd(fts_pkg::CMD_TICK, 3'd0, 32'h0);
        drive_cmd(fts_pkg::CMD_TICK, 3'd0, 32'h0);
        drive_cmd(fts_pkg::CMD_FIFO_EMPTY, 3'd0, 32'h0);
        drain_frames();

        for (int phase = 0; phase < 8; phase++)
        begin
            case (phase)
                0:       load_settings(1'b1, 16'd1, 3'd7);
                1:       load_settings(1'b1, 16'd2, 3'd1);
                2:       load_settings(1'b1, 16'hFFFF, 3'd3);
                3:       load_settings(1'b0, 16'd1, 3'd5);
                4:       load_settings(1'b1, 16'd0, 3'd0);
                default: load_settings($urandom_range(0, 5) != 0,
                                       16'($urandom_range(1, 4)),
                                       3'($urandom_range(0, 7)));
            endcase
            random_commands(32);
            drain_frames();
        end

        repeat (20) @(negedge clk);
        if (mismatch_count == 0)
            $display("float_telemetry_frame_sender verification clean");
        else
            $display("float_telemetry_frame_sender verification failed");
        $finish;
    end

endmodule
